/* sv/hdr_local_tone_map_pixel_macros.svh */
// assertion macros shared by the tone map modules
`ifndef HDR_LOCAL_TONE_MAP_PIXEL_MACROS_SVH
`define HDR_LOCAL_TONE_MAP_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
`define HLTM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HLTM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`else
`define HLTM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define HLTM_ASSERT(lbl, clk, rst, prop, msg)
`endif
`endif

/* sv/hltm_pkg.sv */
package hltm_pkg;

   // field widths
   localparam int LUM_BITS   = 24;
   localparam int MAX_SCALES = 8;
   localparam int SCALE_BITS = 3;
   localparam int BIAS_BITS  = 24;
   localparam int THR_BITS   = 16;
   localparam int RATIO_BITS = 16;
   localparam int INV_BITS   = 24;
   localparam int COUNT_BITS = 4;
   localparam int FRAC_BITS  = 16;
   localparam int ADDR_BITS  = 5;

   // register map, index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_USE_LOCAL     = 3'd0,
      REG_THRESHOLD     = 3'd1,
      REG_INV_WHITE_SQ  = 3'd2,
      REG_SCALE_COUNT   = 3'd3,
      REG_BIAS_FIRST    = 3'd4,
      REG_BIAS_RATIO    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                  use_local;
      logic [THR_BITS-1:0]   activity_threshold;
      logic [INV_BITS-1:0]   inv_white_squared;
      logic [COUNT_BITS-1:0] scale_count;
      logic [BIAS_BITS-1:0]  bias_first;
      logic [RATIO_BITS-1:0] bias_ratio;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      use_local:          1'b0,
      activity_threshold: 16'd3277,
      inv_white_squared:  24'd65536,
      scale_count:        4'd8,
      bias_first:         24'd3019899,
      bias_ratio:         16'd25592
   };

   typedef struct packed {
      logic [LUM_BITS-1:0] luminance;
      logic [LUM_BITS-1:0] blur_0;
      logic [LUM_BITS-1:0] blur_1;
      logic [LUM_BITS-1:0] blur_2;
      logic [LUM_BITS-1:0] blur_3;
      logic [LUM_BITS-1:0] blur_4;
      logic [LUM_BITS-1:0] blur_5;
      logic [LUM_BITS-1:0] blur_6;
      logic [LUM_BITS-1:0] blur_7;
   } req_word_type;

   typedef struct packed {
      logic [LUM_BITS-1:0]   mapped;
      logic [SCALE_BITS-1:0] chosen_scale;
   } rsp_word_type;

endpackage

/* sv/hltm_lane.sv */
module hltm_lane #(
   parameter int LUM_BITS = hltm_pkg::LUM_BITS,
   parameter int SUM_BITS = hltm_pkg::LUM_BITS + 1
) (
   input  logic                          clock,
   input  logic [LUM_BITS-1:0]           a,
   input  logic [LUM_BITS-1:0]           b,
   input  logic [hltm_pkg::BIAS_BITS-1:0] bias,
   input  logic [hltm_pkg::THR_BITS-1:0]  threshold,
   input  logic                          enable,
   output logic                          hit_ff
);

   localparam int PW = SUM_BITS + hltm_pkg::THR_BITS;

   logic [LUM_BITS-1:0] diff;
   logic [SUM_BITS-1:0] den;
   logic [PW-1:0]       lhs;
   logic [PW-1:0]       rhs;
   logic                hit_in;

   // centre-surround activity test by cross multiplication
   always_comb begin
      diff   = (a >= b) ? (a - b) : (b - a);
      den    = SUM_BITS'(bias) + SUM_BITS'(a);
      lhs    = PW'({diff, {hltm_pkg::FRAC_BITS{1'b0}}});
      rhs    = threshold * den;
      hit_in = enable && (lhs > rhs);
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

endmodule

/* sv/hltm_merge.sv */
`include "hdr_local_tone_map_pixel_macros.svh"

module hltm_merge #(
   parameter int LUM_BITS   = hltm_pkg::LUM_BITS,
   parameter int MAX_SCALES = hltm_pkg::MAX_SCALES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                vld,
   input  logic                                use_local,
   input  logic [hltm_pkg::COUNT_BITS-1:0]     count,
   input  logic [MAX_SCALES-2:0]               hit,
   input  logic [LUM_BITS-1:0]                 lum,
   input  logic [LUM_BITS+7:0]                 t,
   input  logic [LUM_BITS-1:0]                 blur [MAX_SCALES],
   output logic                                vld_ff,
   output logic [2*LUM_BITS+8:0]               num_ff,
   output logic [LUM_BITS:0]                   den_ff,
   output logic [hltm_pkg::SCALE_BITS-1:0]     chosen_ff
);

   localparam int LANES = MAX_SCALES - 1;
   localparam int IW    = $clog2(MAX_SCALES);
   localparam int NW    = 2 * LUM_BITS + 9;
   localparam int DW    = LUM_BITS + 1;
   localparam int AW    = LUM_BITS + 9;

   logic [hltm_pkg::SCALE_BITS-1:0] pick;
   logic [LUM_BITS-1:0]             vsel;
   logic [AW-1:0]                   gain;
   logic [NW-1:0]                   num_in;
   logic [DW-1:0]                   den_in;
   logic [hltm_pkg::SCALE_BITS-1:0] chosen_in;

   // first lane that fired, else the last scale in use
   always_comb begin
      pick = hltm_pkg::SCALE_BITS'(count - hltm_pkg::COUNT_BITS'(1));
      for (int i = LANES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pick = hltm_pkg::SCALE_BITS'(i);
         end
      end
      vsel = blur[pick[IW-1:0]];
   end

   // numerator and divisor for the shared divider
   always_comb begin
      gain = AW'(t) + AW'(1 << hltm_pkg::FRAC_BITS);
      if (use_local) begin
         num_in    = NW'(lum) << hltm_pkg::FRAC_BITS;
         den_in    = DW'(1 << hltm_pkg::FRAC_BITS) + DW'(vsel);
         chosen_in = pick;
      end else begin
         num_in    = lum * gain;
         den_in    = DW'(1 << hltm_pkg::FRAC_BITS) + DW'(lum);
         chosen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      den_ff    <= den_in;
      chosen_ff <= chosen_in;
   end

   `HLTM_ASSERT(a_den_nonzero, clock, reset, !(vld_ff && (den_ff < DW'(1 << hltm_pkg::FRAC_BITS))), "divisor below one")
   `HLTM_ASSERT_IMP(a_chosen_range, clock, reset, vld_ff, chosen_ff < hltm_pkg::SCALE_BITS'(MAX_SCALES - 1) || chosen_ff == hltm_pkg::SCALE_BITS'(MAX_SCALES - 1), "chosen scale out of range")

endmodule

/* sv/hltm_div.sv */
`include "hdr_local_tone_map_pixel_macros.svh"

module hltm_div #(
   parameter int NW = 57,
   parameter int DW = 25,
   parameter int QW = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            vld,
   input  logic [NW-1:0]                   num,
   input  logic [DW-1:0]                   den,
   input  logic [hltm_pkg::SCALE_BITS-1:0] chosen,
   output logic                            out_vld,
   output logic [QW-1:0]                   quotient,
   output logic [hltm_pkg::SCALE_BITS-1:0] out_chosen
);

   logic                            vld_ff [QW+1];
   logic                            sat_ff [QW+1];
   logic [DW-1:0]                   r_ff   [QW+1];
   logic [QW-1:0]                   low_ff [QW+1];
   logic [QW-1:0]                   q_ff   [QW+1];
   logic [DW-1:0]                   d_ff   [QW+1];
   logic [hltm_pkg::SCALE_BITS-1:0] ch_ff  [QW+1];
   logic                            sat_in;

   // quotient overflows the field when the high part reaches the divisor
   assign sat_in = (num[NW-1:QW] >= (NW-QW)'(den));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff[0] <= sat_in;
      r_ff[0]   <= num[QW+DW-1:QW];
      low_ff[0] <= num[QW-1:0];
      q_ff[0]   <= '0;
      d_ff[0]   <= den;
      ch_ff[0]  <= chosen;
   end

   // one restoring step, one quotient bit per stage
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW:0]   rem_sh;
      logic [DW:0]   rem_sub;
      logic          ge;
      logic [DW-1:0] r_in;

      always_comb begin
         rem_sh  = {r_ff[k-1], low_ff[k-1][QW-1]};
         rem_sub = rem_sh - {1'b0, d_ff[k-1]};
         ge      = (rem_sh >= {1'b0, d_ff[k-1]});
         r_in    = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         r_ff[k]   <= r_in;
         low_ff[k] <= {low_ff[k-1][QW-2:0], 1'b0};
         q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
         d_ff[k]   <= d_ff[k-1];
         sat_ff[k] <= sat_ff[k-1];
         ch_ff[k]  <= ch_ff[k-1];
      end
   end

   // saturate on overflow
   assign out_vld    = vld_ff[QW];
   assign quotient   = sat_ff[QW] ? {QW{1'b1}} : q_ff[QW];
   assign out_chosen = ch_ff[QW];

   `HLTM_ASSERT_IMP(a_rem_first, clock, reset, vld_ff[0] && !sat_ff[0], r_ff[0] < d_ff[0], "remainder not below divisor at entry")
   `HLTM_ASSERT_IMP(a_rem_last, clock, reset, vld_ff[QW] && !sat_ff[QW], r_ff[QW] < d_ff[QW], "remainder not below divisor at exit")

endmodule

/* sv/hdr_local_tone_map_pixel.sv */
// pipeline: an accepted word passes the input delay line that covers the scale bias line,
// then the lane test, the merge, the divider entry register and one divider stage per
// quotient bit before its result shows.
// throughput: one word per cycle; busy is high only during reset, results cannot be stalled.
// reset: synchronous, clears the pipeline valids and loads the register defaults.
`include "hdr_local_tone_map_pixel_macros.svh"

module hdr_local_tone_map_pixel #(
   parameter int LUM_BITS   = hltm_pkg::LUM_BITS,
   parameter int MAX_SCALES = hltm_pkg::MAX_SCALES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  hltm_pkg::req_word_type           req_word,
   output logic                             rsp_strobe,
   output hltm_pkg::rsp_word_type           rsp_word,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hltm_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int LANES = MAX_SCALES - 1;
   localparam int DLY   = MAX_SCALES - 1;
   localparam int SB    = ((LUM_BITS > hltm_pkg::BIAS_BITS) ? LUM_BITS : hltm_pkg::BIAS_BITS) + 1;
   localparam int TW    = LUM_BITS + 8;
   localparam int NW    = 2 * LUM_BITS + 9;
   localparam int DW    = LUM_BITS + 1;
   localparam int BPW   = hltm_pkg::BIAS_BITS + hltm_pkg::RATIO_BITS;
   localparam int TPW   = LUM_BITS + hltm_pkg::INV_BITS;

   hltm_pkg::cfg_type       cfg_ff;
   hltm_pkg::cfg_type       cfg_in;
   hltm_pkg::reg_index_type wr_index;
   logic                    wr;
   logic                    accept;
   logic [hltm_pkg::COUNT_BITS-1:0] count;

   logic [LUM_BITS-1:0] blur_all [hltm_pkg::MAX_SCALES];
   logic                vld_ff  [DLY+1];
   logic [LUM_BITS-1:0] lum_ff  [DLY+1];
   logic [LUM_BITS-1:0] blur_ff [DLY+1][MAX_SCALES];

   logic [hltm_pkg::BIAS_BITS-1:0] bias_w [LANES];
   logic [LANES-1:0]    hit;
   logic                vld_h_ff;
   logic [LUM_BITS-1:0] lum_h_ff;
   logic [LUM_BITS-1:0] blur_h_ff [MAX_SCALES];
   logic [TW-1:0]       t_h_ff;
   logic [TPW-1:0]      t_prod;

   logic                            m_vld;
   logic [NW-1:0]                   m_num;
   logic [DW-1:0]                   m_den;
   logic [hltm_pkg::SCALE_BITS-1:0] m_chosen;
   logic [LUM_BITS-1:0]             q_mapped;
   logic [hltm_pkg::SCALE_BITS-1:0] q_chosen;

   // handshake
   assign busy   = reset;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // register file
   assign wr       = psel && penable && pwrite && pready;
   assign wr_index = hltm_pkg::reg_index_type'(paddr[hltm_pkg::ADDR_BITS-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (wr_index)
            hltm_pkg::REG_USE_LOCAL:    cfg_in.use_local = pwdata[0];
            hltm_pkg::REG_THRESHOLD:    cfg_in.activity_threshold = pwdata[15:0];
            hltm_pkg::REG_INV_WHITE_SQ: cfg_in.inv_white_squared = pwdata[23:0];
            hltm_pkg::REG_SCALE_COUNT:  cfg_in.scale_count = pwdata[3:0];
            hltm_pkg::REG_BIAS_FIRST:   cfg_in.bias_first = pwdata[23:0];
            hltm_pkg::REG_BIAS_RATIO:   cfg_in.bias_ratio = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= hltm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (wr_index)
         hltm_pkg::REG_USE_LOCAL:    prdata = 32'(cfg_ff.use_local);
         hltm_pkg::REG_THRESHOLD:    prdata = 32'(cfg_ff.activity_threshold);
         hltm_pkg::REG_INV_WHITE_SQ: prdata = 32'(cfg_ff.inv_white_squared);
         hltm_pkg::REG_SCALE_COUNT:  prdata = 32'(cfg_ff.scale_count);
         hltm_pkg::REG_BIAS_FIRST:   prdata = 32'(cfg_ff.bias_first);
         hltm_pkg::REG_BIAS_RATIO:   prdata = 32'(cfg_ff.bias_ratio);
         default:                    prdata = '0;
      endcase
   end

   // scale count clamped to the supported range
   always_comb begin
      count = cfg_ff.scale_count;
      if (cfg_ff.scale_count < hltm_pkg::COUNT_BITS'(2)) begin
         count = hltm_pkg::COUNT_BITS'(2);
      end else if (cfg_ff.scale_count > hltm_pkg::COUNT_BITS'(MAX_SCALES)) begin
         count = hltm_pkg::COUNT_BITS'(MAX_SCALES);
      end
   end

   // per-scale bias line, settles one scale per cycle after a register write
   for (genvar k = 0; k < LANES; k++) begin : g_bias
      if (k == 0) begin : g_first
         assign bias_w[k] = cfg_ff.bias_first;
      end else begin : g_next
         logic [BPW-1:0]                 prod;
         logic [hltm_pkg::BIAS_BITS-1:0] bias_ff;
         assign prod = bias_w[k-1] * cfg_ff.bias_ratio;
         always_ff @(posedge clock) begin
            bias_ff <= prod[BPW-1:hltm_pkg::FRAC_BITS];
         end
         assign bias_w[k] = bias_ff;
      end
   end

   // unpack the input word
   assign blur_all[0] = req_word.blur_0;
   assign blur_all[1] = req_word.blur_1;
   assign blur_all[2] = req_word.blur_2;
   assign blur_all[3] = req_word.blur_3;
   assign blur_all[4] = req_word.blur_4;
   assign blur_all[5] = req_word.blur_5;
   assign blur_all[6] = req_word.blur_6;
   assign blur_all[7] = req_word.blur_7;

   // input delay line, covers the bias line settling
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DLY; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int j = 1; j <= DLY; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      lum_ff[0] <= req_word.luminance;
      for (int i = 0; i < MAX_SCALES; i++) begin
         blur_ff[0][i] <= blur_all[i];
      end
      for (int j = 1; j <= DLY; j++) begin
         lum_ff[j] <= lum_ff[j-1];
         for (int i = 0; i < MAX_SCALES; i++) begin
            blur_ff[j][i] <= blur_ff[j-1][i];
         end
      end
   end

   // activity lanes, one per adjacent scale pair
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      hltm_lane #(
         .LUM_BITS (LUM_BITS),
         .SUM_BITS (SB)
      ) u_lane (
         .clock     (clock),
         .a         (blur_ff[DLY][i]),
         .b         (blur_ff[DLY][i+1]),
         .bias      (bias_w[i]),
         .threshold (cfg_ff.activity_threshold),
         .enable    (hltm_pkg::COUNT_BITS'(i + 1) < count),
         .hit_ff    (hit[i])
      );
   end

   // global curve term, alongside the lanes
   assign t_prod = lum_ff[DLY] * cfg_ff.inv_white_squared;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_h_ff <= 1'b0;
      end else begin
         vld_h_ff <= vld_ff[DLY];
      end
   end

   always_ff @(posedge clock) begin
      lum_h_ff <= lum_ff[DLY];
      t_h_ff   <= t_prod[TPW-1:hltm_pkg::FRAC_BITS];
      for (int i = 0; i < MAX_SCALES; i++) begin
         blur_h_ff[i] <= blur_ff[DLY][i];
      end
   end

   hltm_merge #(
      .LUM_BITS   (LUM_BITS),
      .MAX_SCALES (MAX_SCALES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .vld       (vld_h_ff),
      .use_local (cfg_ff.use_local),
      .count     (count),
      .hit       (hit),
      .lum       (lum_h_ff),
      .t         (t_h_ff),
      .blur      (blur_h_ff),
      .vld_ff    (m_vld),
      .num_ff    (m_num),
      .den_ff    (m_den),
      .chosen_ff (m_chosen)
   );

   hltm_div #(
      .NW (NW),
      .DW (DW),
      .QW (LUM_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .vld        (m_vld),
      .num        (m_num),
      .den        (m_den),
      .chosen     (m_chosen),
      .out_vld    (rsp_strobe),
      .quotient   (q_mapped),
      .out_chosen (q_chosen)
   );

   assign rsp_word.mapped       = q_mapped;
   assign rsp_word.chosen_scale = q_chosen;

   `HLTM_ASSERT_IMP(a_busy_in_reset, clock, 1'b0, reset, busy, "busy low during reset")

endmodule
